>>> src/hpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpa_pkg;

    // default sizes
    localparam int DEF_STACK_DEPTH = 32;
    localparam int DEF_HANDLE_BITS = 32;
    localparam int DEF_COUNT_BITS  = 16;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int USE_OUT_W = 16;
    localparam int PINNED_W  = 6;
    localparam int PERIOD_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 32'd60;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PINNED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;

    // commands
    localparam logic [CMD_W-1:0] CMD_GET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GOT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RETURNED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DESTROY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TICK_DONE = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GETW,
        S_EMIT,
        S_DRD,
        S_DOUT,
        S_MCHK,
        S_MWR
    } t_state;

endpackage

`default_nettype wire

>>> src/hpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/handle_pool_with_aging_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// handle pool with aging: caches free handles in an active and an inactive lifo stack
// input channel s_axis: tuser carries the command (get, return, tick), tdata the handle
// being returned; one word is taken only while the sequencer is idle
// output channel m_axis: one or more result words per input word, tlast on the final one;
// a registered output stage lets the next input word be taken while a result waits
// get and return pass the exec step and then a result step (getw for a get that hits, reading
// the stack through the registered ram read; emit otherwise); the next word waits for that result
// a tick that expires the aging timer walks the stacks: a ram read, then a result, per destroyed
// handle, and a ram read, then a write, per handle moved from active to inactive,
// at most 2 * stack_depth handles in all
// the two stacks live in two rams; when everything ages the banks swap roles,
// so no copy pass is needed
// reset clears all counts, the timer and the output stage; the ram contents are
// left as they are, the counts guard every read
// a stalled receiver holds the result word and the sequencer waits before loading
// the next one; configuration writes are taken at any time but expected while idle

module handle_pool_with_aging_unit #(
    parameter int STACK_DEPTH = hpa_pkg::DEF_STACK_DEPTH,
    parameter int HANDLE_BITS = hpa_pkg::DEF_HANDLE_BITS,
    parameter int COUNT_BITS  = hpa_pkg::DEF_COUNT_BITS,
    localparam int IN_DW  = ((HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_DW = ((HANDLE_BITS + 2 * hpa_pkg::USE_OUT_W + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [hpa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [IN_DW-1:0]                s_axis_tdata,   // handle_in
    input  wire logic [hpa_pkg::CMD_W-1:0]       s_axis_tuser,   // cmd
    // result words
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [OUT_DW-1:0]                    m_axis_tdata,   // handle_out, in_use_now,
                                                                 // peak_in_use
    output logic [hpa_pkg::STATUS_W-1:0]         m_axis_tuser,   // status
    output logic                                 m_axis_tlast
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int TOT_W  = ((COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W) + 2;
    localparam logic [CNT_W-1:0]      FULL = CNT_W'(STACK_DEPTH);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam int UW = hpa_pkg::USE_OUT_W;

    // state
    hpa_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]                r_act_cnt, n_act_cnt;
    logic [CNT_W-1:0]                r_inact_cnt, n_inact_cnt;
    logic                            r_act_sel, n_act_sel;     // ram bank of active stack
    logic [COUNT_BITS-1:0]           r_in_use, n_in_use;
    logic [COUNT_BITS-1:0]           r_peak, n_peak;
    logic                            r_armed, n_armed;
    logic [hpa_pkg::PERIOD_W-1:0]    r_ticks, n_ticks;
    logic [hpa_pkg::PINNED_W-1:0]    r_pinned, n_pinned;
    logic [hpa_pkg::PERIOD_W-1:0]    r_period, n_period;

    // latched input word
    logic [hpa_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [HANDLE_BITS-1:0]          r_handle, n_handle;

    // aging walk
    logic [ADDR_W-1:0]               r_walk, n_walk;
    logic [CNT_W-1:0]                r_left, n_left;
    logic                            r_walk_up, n_walk_up;
    logic                            r_do_moves, n_do_moves;
    logic                            r_had_destroy, n_had_destroy;
    logic [hpa_pkg::STATUS_W-1:0]    r_pend_status, n_pend_status;

    // ram read address, held so the read data stays put while the output stalls
    logic [ADDR_W-1:0]               r_rd_addr, rd_addr;
    logic                            r_rd_bank, rd_bank;

    // output stage
    logic                            r_out_valid;
    logic [hpa_pkg::STATUS_W-1:0]    r_out_status;
    logic [HANDLE_BITS-1:0]          r_out_handle;
    logic                            r_out_last;
    logic [UW-1:0]                   r_out_use;
    logic [UW-1:0]                   r_out_peak;

    // ram ports
    logic [1:0]                      wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [HANDLE_BITS-1:0]          wr_data;
    logic [HANDLE_BITS-1:0]          rdata0, rdata1, rd_data;

    // output load controls
    logic                            out_load;
    logic [hpa_pkg::STATUS_W-1:0]    out_status;
    logic [HANDLE_BITS-1:0]          out_handle;
    logic                            out_last;

    // shared decisions
    logic                            in_acc;
    logic                            can_load;
    logic                            has_act, has_inact, act_full, mv_ok;
    logic [CNT_W-1:0]                act_m1, inact_m1;
    logic [hpa_pkg::PERIOD_W-1:0]    tick_next;
    logic                            tick_fire;
    logic                            pin_on;
    logic [TOT_W-1:0]                total, excess;
    logic                            over;
    logic [CNT_W-1:0]                n_destroy;
    logic [COUNT_BITS+UW-1:0]        use_ext, peak_ext;

    hpa_ram #(.WIDTH(HANDLE_BITS), .DEPTH(STACK_DEPTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (wr_en[0]),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata0)
    );

    hpa_ram #(.WIDTH(HANDLE_BITS), .DEPTH(STACK_DEPTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (wr_en[1]),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata1)
    );

    assign rd_data   = r_rd_bank ? rdata1 : rdata0;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign can_load  = !r_out_valid || m_axis_tready;
    assign has_act   = r_act_cnt != '0;
    assign has_inact = r_inact_cnt != '0;
    assign act_full  = r_act_cnt == FULL;
    assign mv_ok     = has_act && (r_inact_cnt != FULL);
    assign act_m1    = r_act_cnt - CNT_W'(1);
    assign inact_m1  = r_inact_cnt - CNT_W'(1);
    assign tick_next = (r_ticks != '0) ? r_ticks - 32'd1 : '0;
    assign tick_fire = (r_cmd == hpa_pkg::CMD_TICK) && r_armed && (tick_next == '0);
    assign pin_on    = r_pinned != '0;

    // pinned pass: excess over the pinned count, clipped to what the inactive stack holds
    assign total     = TOT_W'(r_act_cnt) + TOT_W'(r_inact_cnt) + TOT_W'(r_in_use);
    assign over      = total > TOT_W'(r_pinned);
    assign excess    = total - TOT_W'(r_pinned);
    assign n_destroy = (excess >= TOT_W'(r_inact_cnt)) ? r_inact_cnt : excess[CNT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = hpa_pkg::S_EXEC;
                end
            end
            hpa_pkg::S_EXEC: begin
                n_state = hpa_pkg::S_EMIT;
                if (r_cmd == hpa_pkg::CMD_GET) begin
                    if (has_act || has_inact) begin
                        n_state = hpa_pkg::S_GETW;
                    end
                end else if (tick_fire) begin
                    if (pin_on) begin
                        if (over) begin
                            n_state = (n_destroy != '0) ? hpa_pkg::S_DRD : hpa_pkg::S_MCHK;
                        end
                    end else if (has_inact) begin
                        n_state = hpa_pkg::S_DRD;
                    end
                end
            end
            hpa_pkg::S_GETW, hpa_pkg::S_EMIT: begin
                if (can_load) begin
                    n_state = hpa_pkg::S_IDLE;
                end
            end
            hpa_pkg::S_DRD: begin
                n_state = hpa_pkg::S_DOUT;
            end
            hpa_pkg::S_DOUT: begin
                if (can_load) begin
                    if (r_left == CNT_W'(1)) begin
                        n_state = r_do_moves ? hpa_pkg::S_MCHK : hpa_pkg::S_IDLE;
                    end else begin
                        n_state = hpa_pkg::S_DRD;
                    end
                end
            end
            hpa_pkg::S_MCHK: begin
                if (mv_ok) begin
                    n_state = hpa_pkg::S_MWR;
                end else begin
                    n_state = r_had_destroy ? hpa_pkg::S_IDLE : hpa_pkg::S_EMIT;
                end
            end
            hpa_pkg::S_MWR: begin
                n_state = hpa_pkg::S_MCHK;
            end
            default: begin
                n_state = hpa_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: handshake, ram controls, result loads
    always_comb begin
        s_axis_tready = (r_state == hpa_pkg::S_IDLE);
        rd_addr    = r_rd_addr;
        rd_bank    = r_rd_bank;
        wr_en      = 2'b00;
        wr_addr    = '0;
        wr_data    = '0;
        out_load   = 1'b0;
        out_status = r_pend_status;
        out_handle = '0;
        out_last   = 1'b1;
        unique case (r_state)
            hpa_pkg::S_EXEC: begin
                case (r_cmd)
                    hpa_pkg::CMD_GET: begin
                        // pop active top, else inactive top
                        rd_addr = has_act ? act_m1[ADDR_W-1:0] : inact_m1[ADDR_W-1:0];
                        rd_bank = has_act ? r_act_sel : !r_act_sel;
                    end
                    hpa_pkg::CMD_PUT: begin
                        if (!act_full) begin
                            wr_en[r_act_sel] = 1'b1;
                            wr_addr = r_act_cnt[ADDR_W-1:0];
                            wr_data = r_handle;
                        end
                    end
                    default: begin
                        // destroy walk reads the inactive bank as it is now
                        rd_bank = !r_act_sel;
                    end
                endcase
            end
            hpa_pkg::S_GETW: begin
                out_load   = can_load;
                out_status = hpa_pkg::ST_GOT;
                out_handle = rd_data;
            end
            hpa_pkg::S_EMIT: begin
                out_load = can_load;
            end
            hpa_pkg::S_DRD: begin
                rd_addr = r_walk;
            end
            hpa_pkg::S_DOUT: begin
                out_load   = can_load;
                out_status = hpa_pkg::ST_DESTROY;
                out_handle = rd_data;
                out_last   = (r_left == CNT_W'(1));
            end
            hpa_pkg::S_MCHK: begin
                rd_addr = act_m1[ADDR_W-1:0];
                rd_bank = r_act_sel;
            end
            hpa_pkg::S_MWR: begin
                wr_en[!r_act_sel] = 1'b1;
                wr_addr = r_inact_cnt[ADDR_W-1:0];
                wr_data = rd_data;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_act_cnt     = r_act_cnt;
        n_inact_cnt   = r_inact_cnt;
        n_act_sel     = r_act_sel;
        n_in_use      = r_in_use;
        n_peak        = r_peak;
        n_armed       = r_armed;
        n_ticks       = r_ticks;
        n_pinned      = r_pinned;
        n_period      = r_period;
        n_cmd         = r_cmd;
        n_handle      = r_handle;
        n_walk        = r_walk;
        n_left        = r_left;
        n_walk_up     = r_walk_up;
        n_do_moves    = r_do_moves;
        n_had_destroy = r_had_destroy;
        n_pend_status = r_pend_status;

        unique case (r_state)
            hpa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = s_axis_tuser;
                    n_handle = s_axis_tdata[HANDLE_BITS-1:0];
                end
            end
            hpa_pkg::S_EXEC: begin
                n_pend_status = hpa_pkg::ST_TICK_DONE;
                case (r_cmd)
                    hpa_pkg::CMD_GET: begin
                        n_pend_status = hpa_pkg::ST_MISS;
                        if (has_act) begin
                            n_act_cnt = act_m1;
                        end else if (has_inact) begin
                            n_inact_cnt = inact_m1;
                        end
                        if (r_in_use != CMAX) begin
                            n_in_use = r_in_use + COUNT_BITS'(1);
                        end
                        if (n_in_use > r_peak) begin
                            n_peak = n_in_use;
                        end
                    end
                    hpa_pkg::CMD_PUT: begin
                        if (act_full) begin
                            n_pend_status = hpa_pkg::ST_REJECTED;
                        end else begin
                            n_pend_status = hpa_pkg::ST_RETURNED;
                            // first handle into an empty active stack arms the timer
                            if (!has_act && !r_armed) begin
                                n_armed = 1'b1;
                                n_ticks = r_period;
                            end
                            n_act_cnt = r_act_cnt + CNT_W'(1);
                            if (r_in_use != '0) begin
                                n_in_use = r_in_use - COUNT_BITS'(1);
                            end
                        end
                    end
                    hpa_pkg::CMD_TICK: begin
                        if (r_armed) begin
                            n_ticks = tick_next;
                            if (tick_fire) begin
                                n_armed       = 1'b0;
                                n_had_destroy = 1'b0;
                                n_do_moves    = 1'b0;
                                if (pin_on) begin
                                    if (over) begin
                                        // destroy from the inactive top, then move
                                        n_walk        = inact_m1[ADDR_W-1:0];
                                        n_walk_up     = 1'b0;
                                        n_left        = n_destroy;
                                        n_inact_cnt   = r_inact_cnt - n_destroy;
                                        n_had_destroy = n_destroy != '0;
                                        n_do_moves    = 1'b1;
                                        if (has_act) begin
                                            n_armed = 1'b1;
                                            n_ticks = r_period;
                                        end
                                    end
                                end else begin
                                    // destroy all inactive bottom up; banks swap roles if the active stack holds any
                                    n_walk        = '0;
                                    n_walk_up     = 1'b1;
                                    n_left        = r_inact_cnt;
                                    n_had_destroy = has_inact;
                                    n_inact_cnt   = '0;
                                    if (has_act) begin
                                        n_inact_cnt = r_act_cnt;
                                        n_act_cnt   = '0;
                                        n_act_sel   = !r_act_sel;
                                        n_armed     = 1'b1;
                                        n_ticks     = r_period;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            hpa_pkg::S_DOUT: begin
                if (can_load) begin
                    n_left = r_left - CNT_W'(1);
                    n_walk = r_walk_up ? r_walk + ADDR_W'(1) : r_walk - ADDR_W'(1);
                end
            end
            hpa_pkg::S_MCHK: begin
                if (mv_ok) begin
                    n_act_cnt = act_m1;
                end
            end
            hpa_pkg::S_MWR: begin
                n_inact_cnt = r_inact_cnt + CNT_W'(1);
            end
            default: begin
            end
        endcase

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                hpa_pkg::CFG_PINNED: begin
                    // age on the next tick
                    n_pinned = i_cfg_data[hpa_pkg::PINNED_W-1:0];
                    n_armed  = 1'b1;
                    n_ticks  = 32'd1;
                end
                hpa_pkg::CFG_PERIOD: begin
                    if (i_cfg_data != '0) begin
                        n_period = i_cfg_data[hpa_pkg::PERIOD_W-1:0];
                        n_armed  = 1'b1;
                        n_ticks  = i_cfg_data[hpa_pkg::PERIOD_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hpa_pkg::S_IDLE;
            r_act_cnt     <= '0;
            r_inact_cnt   <= '0;
            r_act_sel     <= 1'b0;
            r_in_use      <= '0;
            r_peak        <= '0;
            r_armed       <= 1'b0;
            r_ticks       <= '0;
            r_pinned      <= '0;
            r_period      <= hpa_pkg::DEFAULT_PERIOD;
            r_do_moves    <= 1'b0;
            r_had_destroy <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_act_cnt     <= n_act_cnt;
            r_inact_cnt   <= n_inact_cnt;
            r_act_sel     <= n_act_sel;
            r_in_use      <= n_in_use;
            r_peak        <= n_peak;
            r_armed       <= n_armed;
            r_ticks       <= n_ticks;
            r_pinned      <= n_pinned;
            r_period      <= n_period;
            r_do_moves    <= n_do_moves;
            r_had_destroy <= n_had_destroy;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_handle      <= n_handle;
        r_walk        <= n_walk;
        r_left        <= n_left;
        r_walk_up     <= n_walk_up;
        r_pend_status <= n_pend_status;
        r_rd_addr     <= rd_addr;
        r_rd_bank     <= rd_bank;
        if (out_load) begin
            r_out_status <= out_status;
            r_out_handle <= out_handle;
            r_out_last   <= out_last;
            r_out_use    <= use_ext[UW-1:0];
            r_out_peak   <= peak_ext[UW-1:0];
        end
    end

    // low bits of the counts, zero extended for narrow count widths
    assign use_ext  = {{UW{1'b0}}, r_in_use};
    assign peak_ext = {{UW{1'b0}}, r_peak};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_DW'({r_out_peak, r_out_use, r_out_handle});

    // an armed timer always has ticks to count
    a_armed_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_ticks != '0))
        else $error("armed timer with zero ticks");

    // stack counts stay within the depth
    a_act_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_cnt <= FULL)
        else $error("active count beyond depth");

    a_inact_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inact_cnt <= FULL)
        else $error("inactive count beyond depth");

    // a move write never lands past the inactive top
    a_move_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpa_pkg::S_MWR) |-> (r_inact_cnt != FULL) && $past(mv_ok))
        else $error("move into a full inactive stack");

endmodule

`default_nettype wire
